// ===== src/ptw_pkg.sv =====
// Shared types, codes and helpers for the page table walker.
`default_nettype none

package ptw_pkg;

  localparam int ADDR_W  = 52;
  localparam int VA_W    = 48;
  localparam int PTE_W   = 64;
  localparam int FRAME_W = 40;

  // input item kind
  localparam logic ITEM_XLATE = 1'b0;
  localparam logic ITEM_RESP  = 1'b1;

  // result kind
  localparam logic RK_READ = 1'b0;
  localparam logic RK_DONE = 1'b1;

  // status codes
  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_NOT_PRESENT = 2'd1;
  localparam logic [1:0] ST_PROTO_ERR   = 2'd2;

  // page size codes
  localparam logic [1:0] PS_4K = 2'd0;
  localparam logic [1:0] PS_2M = 2'd1;
  localparam logic [1:0] PS_1G = 2'd2;

  // table levels
  localparam logic [1:0] LVL_PML4 = 2'd0;
  localparam logic [1:0] LVL_PDPT = 2'd1;
  localparam logic [1:0] LVL_PD   = 2'd2;
  localparam logic [1:0] LVL_PT   = 2'd3;

  localparam int PTE_PRESENT_BIT = 0;
  localparam int PTE_HUGE_BIT    = 7;

  // Queue entry: a request keeps its vaddr in the low bits of payload,
  // a response keeps the whole entry.
  typedef struct packed {
    logic             kind;
    logic [PTE_W-1:0] payload;
  } q_item_t;

  function automatic logic [8:0] level_index(input logic [VA_W-1:0] va,
                                             input logic [1:0] lvl);
    logic [8:0] idx;
    begin
      unique case (lvl)
        LVL_PML4: idx = va[47:39];
        LVL_PDPT: idx = va[38:30];
        LVL_PD:   idx = va[29:21];
        LVL_PT:   idx = va[20:12];
        default:  idx = va[47:39];
      endcase
      return idx;
    end
  endfunction

endpackage

`default_nettype wire

// ===== src/page_table_walk_translate_core.sv =====
// Top level of the four-level page table walker: config register, front end, back end.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-----------------------------------------
//  in_     | input     | in_valid / in_stall  | in_kind, in_virt_addr, in_mem_data
//  out_    | output    | out_valid / out_stall| out_result_kind, out_read_addr,
//          |           |                      | out_phys_addr, out_status, out_page_size
//  cfg_    | input     | cfg_wr_en            | cfg_wr_data (root_frame)
//
// One beat in gives one beat out. Sustained rate is one beat per cycle while
// out_stall is low; an input beat passes through a queue entry before the
// result register, and the single back-end decode step sets that rate.
// Reset is synchronous and active low; it clears the queue, the walk state,
// the result valid and root_frame. in_stall rises only when the two-entry
// queue is full, so a held out_stall stalls the input once the result
// register and both queue entries hold beats.
`default_nettype none

module page_table_walk_translate_core
  import ptw_pkg::*;
#(
  parameter int PHYS_ADDR_BITS = 52
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  // input channel
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic                in_kind,
  input  wire logic [VA_W-1:0]     in_virt_addr,
  input  wire logic [PTE_W-1:0]    in_mem_data,
  // result channel
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic                     out_result_kind,
  output logic [ADDR_W-1:0]        out_read_addr,
  output logic [ADDR_W-1:0]        out_phys_addr,
  output logic [1:0]               out_status,
  output logic [1:0]               out_page_size,
  // configuration
  input  wire logic                cfg_wr_en,
  input  wire logic [FRAME_W-1:0]  cfg_wr_data
);

  // PML4 base frame (CR3-like); the user must write it only while idle; the block does not enforce this
  logic [FRAME_W-1:0] root_frame_r, root_frame_nxt;

  // front -> back queue head
  logic    head_valid;
  q_item_t head_item;
  logic    head_pop;

  assign root_frame_nxt = cfg_wr_en ? cfg_wr_data : root_frame_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_frame_r <= '0;
    end else begin
      root_frame_r <= root_frame_nxt;
    end
  end

  // front: takes beats, keeps only the field the kind needs
  ptw_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_kind      (in_kind),
    .in_virt_addr (in_virt_addr),
    .in_mem_data  (in_mem_data),
    .head_valid   (head_valid),
    .head_item    (head_item),
    .head_pop     (head_pop)
  );

  // back: one table level per beat, result held in an output register
  ptw_back #(
    .PHYS_ADDR_BITS (PHYS_ADDR_BITS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .root_frame      (root_frame_r),
    .head_valid      (head_valid),
    .head_item       (head_item),
    .head_pop        (head_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_result_kind (out_result_kind),
    .out_read_addr   (out_read_addr),
    .out_phys_addr   (out_phys_addr),
    .out_status      (out_status),
    .out_page_size   (out_page_size)
  );

endmodule

`default_nettype wire

// ===== src/ptw_front.sv =====
// Front end: accepts input beats, folds them into queue entries, two-deep queue.
`default_nettype none

module ptw_front
  import ptw_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              in_kind,
  input  wire logic [VA_W-1:0]   in_virt_addr,
  input  wire logic [PTE_W-1:0]  in_mem_data,
  output logic                   head_valid,
  output q_item_t                head_item,
  input  wire logic              head_pop
);

  q_item_t    q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       push;
  q_item_t    push_item;

  assign in_stall   = (count_r == 2'd2);
  assign push       = in_valid && !in_stall;
  assign head_valid = (count_r != 2'd0);
  assign head_item  = q_r[rd_ptr_r];

  // classify: keep only the field the kind uses
  always_comb begin
    push_item.kind = in_kind;
    if (in_kind == ITEM_XLATE) begin
      push_item.payload = {{(PTE_W-VA_W){1'b0}}, in_virt_addr};
    end else begin
      push_item.payload = in_mem_data;
    end
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ head_pop;
    count_nxt  = count_r + {1'b0, push} - {1'b0, head_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_item;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != 2'd3)
    else $error("queue count out of range");

  a_ptr_parity: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_ptr_r ^ rd_ptr_r) == count_r[0])
    else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

// ===== src/ptw_back.sv =====
// Back end: walk state, per-level decode and the result register.
`default_nettype none

module ptw_back
  import ptw_pkg::*;
#(
  parameter int PHYS_ADDR_BITS = 52
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic [FRAME_W-1:0]  root_frame,
  input  wire logic                head_valid,
  input  wire q_item_t             head_item,
  output logic                     head_pop,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic                     out_result_kind,
  output logic [ADDR_W-1:0]        out_read_addr,
  output logic [ADDR_W-1:0]        out_phys_addr,
  output logic [1:0]               out_status,
  output logic [1:0]               out_page_size
);

  localparam logic [ADDR_W-1:0] PA_MASK =
    (ADDR_W'(1) << PHYS_ADDR_BITS) - ADDR_W'(1);

  logic              walk_active_r, walk_active_nxt;
  logic [1:0]        walk_level_r, walk_level_nxt;
  logic [VA_W-1:0]   held_vaddr_r, held_vaddr_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic              out_result_kind_r, out_result_kind_nxt;
  logic [ADDR_W-1:0] out_read_addr_r, out_read_addr_nxt;
  logic [ADDR_W-1:0] out_phys_addr_r, out_phys_addr_nxt;
  logic [1:0]        out_status_r, out_status_nxt;
  logic [1:0]        out_page_size_r, out_page_size_nxt;

  logic [PTE_W-1:0]  pte;
  logic [VA_W-1:0]   req_va;
  logic [1:0]        lvl_up;
  logic              present, huge;

  // result slot frees when empty or being taken this cycle
  assign head_pop = head_valid && (!out_valid_r || !out_stall);

  assign pte     = head_item.payload;
  assign req_va  = head_item.payload[VA_W-1:0];
  assign lvl_up  = walk_level_r + 2'd1;
  assign present = pte[PTE_PRESENT_BIT];
  assign huge    = pte[PTE_HUGE_BIT];

  always_comb begin
    walk_active_nxt     = walk_active_r;
    walk_level_nxt      = walk_level_r;
    held_vaddr_nxt      = held_vaddr_r;
    out_valid_nxt       = out_valid_r && out_stall;
    out_result_kind_nxt = RK_DONE;
    out_read_addr_nxt   = '0;
    out_phys_addr_nxt   = '0;
    out_status_nxt      = ST_OK;
    out_page_size_nxt   = PS_4K;
    if (head_pop) begin
      out_valid_nxt = 1'b1;
      if (head_item.kind == ITEM_XLATE) begin
        if (walk_active_r) begin
          out_status_nxt = ST_PROTO_ERR;
        end else begin
          held_vaddr_nxt      = req_va;
          walk_level_nxt      = LVL_PML4;
          walk_active_nxt     = 1'b1;
          out_result_kind_nxt = RK_READ;
          out_read_addr_nxt   =
            {root_frame, level_index(req_va, LVL_PML4), 3'b000} & PA_MASK;
        end
      end else if (!walk_active_r) begin
        out_status_nxt = ST_PROTO_ERR;
      end else if (!present) begin
        walk_active_nxt = 1'b0;
        walk_level_nxt  = LVL_PML4;
        out_status_nxt  = ST_NOT_PRESENT;
      end else if (walk_level_r == LVL_PDPT && huge) begin
        walk_active_nxt   = 1'b0;
        walk_level_nxt    = LVL_PML4;
        out_phys_addr_nxt = {pte[51:30], held_vaddr_r[29:0]} & PA_MASK;
        out_page_size_nxt = PS_1G;
      end else if (walk_level_r == LVL_PD && huge) begin
        walk_active_nxt   = 1'b0;
        walk_level_nxt    = LVL_PML4;
        out_phys_addr_nxt = {pte[51:21], held_vaddr_r[20:0]} & PA_MASK;
        out_page_size_nxt = PS_2M;
      end else if (walk_level_r == LVL_PT) begin
        walk_active_nxt   = 1'b0;
        walk_level_nxt    = LVL_PML4;
        out_phys_addr_nxt = {pte[51:12], held_vaddr_r[11:0]} & PA_MASK;
        out_page_size_nxt = PS_4K;
      end else begin
        // descend; huge bit in a PML4 entry is ignored
        walk_level_nxt      = lvl_up;
        out_result_kind_nxt = RK_READ;
        out_read_addr_nxt   =
          {pte[51:12], level_index(held_vaddr_r, lvl_up), 3'b000} & PA_MASK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      walk_active_r <= 1'b0;
      walk_level_r  <= LVL_PML4;
      held_vaddr_r  <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      walk_active_r <= walk_active_nxt;
      walk_level_r  <= walk_level_nxt;
      held_vaddr_r  <= held_vaddr_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (head_pop) begin
      out_result_kind_r <= out_result_kind_nxt;
      out_read_addr_r   <= out_read_addr_nxt;
      out_phys_addr_r   <= out_phys_addr_nxt;
      out_status_r      <= out_status_nxt;
      out_page_size_r   <= out_page_size_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result_kind = out_result_kind_r;
  assign out_read_addr   = out_read_addr_r;
  assign out_phys_addr   = out_phys_addr_r;
  assign out_status      = out_status_r;
  assign out_page_size   = out_page_size_r;

  a_idle_level: assert property (@(posedge clk) disable iff (!rst_n)
    !walk_active_r |-> walk_level_r == LVL_PML4)
    else $error("level nonzero while idle");

  a_read_means_walking: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_result_kind_r == RK_READ) |-> walk_active_r)
    else $error("read beat pending with no walk in progress");

  a_fault_no_pa: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != ST_OK) |-> out_phys_addr_r == '0)
    else $error("fault beat carries a physical address");

endmodule

`default_nettype wire
